// ===== rtl/i2cts_pkg.sv =====
// i2cts_pkg: types, codes and sizes shared by the two-wire transfer sequencer.
// No dependencies; every rtl file imports it.
`timescale 1ns / 1ps

package i2cts_pkg;

   localparam int BUF_DEPTH = 128;
   localparam int BUF_AW = $clog2(BUF_DEPTH);
   localparam logic [7:0] SEND_MAX = 8'(BUF_DEPTH);
   localparam logic [6:0] OWN_ADDR_DEFAULT = 7'd2;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_EVENT = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_SEND      = 2'd0,
      KIND_RECV      = 2'd1,
      KIND_SEND_RECV = 2'd2,
      KIND_NONE      = 2'd3
   } kind_type;

   // bus status events; codes above ST_NO_INFO are unknown
   typedef enum logic [4:0] {
      ST_START        = 5'd0,
      ST_REP_START    = 5'd1,
      ST_MT_SLA_ACK   = 5'd2,
      ST_MT_DATA_ACK  = 5'd3,
      ST_ARB_LOST     = 5'd4,
      ST_MR_SLA_ACK   = 5'd5,
      ST_MR_DATA_ACK  = 5'd6,
      ST_MR_DATA_NACK = 5'd7,
      ST_SR_SLA_ACK   = 5'd8,
      ST_SR_ARB_LOST  = 5'd9,
      ST_SR_DATA_ACK  = 5'd10,
      ST_SR_STOP      = 5'd11,
      ST_ST_SLA_ACK   = 5'd12,
      ST_ST_DATA_ACK  = 5'd13,
      ST_ST_DATA_NACK = 5'd14,
      ST_ST_LAST_ACK  = 5'd15,
      ST_BUS_ERROR    = 5'd16,
      ST_NO_INFO      = 5'd17
   } status_type;

   localparam logic READ_BIT = 1'b1;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] transfer_kind;
      logic [6:0] target_addr;
      logic [7:0] send_count;
      logic [7:0] recv_count;
      logic [6:0] load_index;
      logic [7:0] load_byte;
      logic [4:0] status_code;
      logic [7:0] bus_byte;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [7:0] drive_byte;
      logic       drive_valid;
      logic       issue_start;
      logic       issue_stop;
      logic       ack_next;
      logic       busy_flag;
      logic       result_ok;
      logic       rx_valid;
      logic [6:0] rx_position;
      logic [7:0] rx_value;
      logic [7:0] slave_packet_len;
   } rsp_type;

   // handshake between input stage and the sequencing core
   typedef struct packed {
      logic step;
   } flow_type;

endpackage

// ===== rtl/i2cts_tx_mem.sv =====
// i2cts_tx_mem: transmit byte buffer, one write port and one registered read port.
// Read is write-first so a byte loaded at the read address shows up at once.
// Depends on i2cts_pkg.
`timescale 1ns / 1ps

module i2cts_tx_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [i2cts_pkg::BUF_AW-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic [i2cts_pkg::BUF_AW-1:0] rd_addr,
   output logic [7:0]                 rd_data
);
   import i2cts_pkg::*;

   logic [7:0] mem [BUF_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/i2cts_in_stage.sv =====
// i2cts_in_stage: input register of the sequencer, with stall back to the requester.
// Depends on i2cts_pkg.
`timescale 1ns / 1ps

module i2cts_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  i2cts_pkg::req_type req_data,
   input  logic               out_free,
   output i2cts_pkg::flow_type flow,
   output i2cts_pkg::req_type item
);
   import i2cts_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff;
   logic    step;
   logic    take;

   assign step      = valid_ff & out_free;
   assign req_stall = valid_ff & ~step;
   assign take      = req_valid & ~req_stall;
   assign valid_in  = take | (valid_ff & ~step);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_data;
      end
   end

   assign flow.step = step;
   assign item      = item_ff;

endmodule

// ===== rtl/i2cts_seq_core.sv =====
// i2cts_seq_core: transfer state registers and the per-request decode that
// produces the next bus action. Depends on i2cts_pkg and i2cts_tx_mem.
`timescale 1ns / 1ps

module i2cts_seq_core (
   input  logic                clock,
   input  logic                reset,
   input  i2cts_pkg::flow_type flow,
   input  i2cts_pkg::req_type  item,
   input  logic                csr_we,
   input  logic [6:0]          csr_wdata,
   output i2cts_pkg::rsp_type  result
);
   import i2cts_pkg::*;

   kind_type   kind_ff, kind_in;
   logic [6:0] addr_ff, addr_in;
   logic [7:0] send_len_ff, send_len_in;
   logic [7:0] recv_len_ff, recv_len_in;
   logic [7:0] sent_ff, sent_in;
   logic [7:0] recv_pos_ff, recv_pos_in;
   logic [7:0] slave_pos_ff, slave_pos_in;
   logic       busy_ff, busy_in;
   logic       ok_ff, ok_in;
   logic [6:0] own_addr_ff, own_addr_in;

   logic       idle_ret;
   logic [7:0] tx_byte;
   logic [7:0] send_clamp;
   logic [7:0] pos_inc;
   logic       mem_we;
   logic [BUF_AW-1:0] mem_raddr;
   op_type     op;
   kind_type   req_kind;
   status_type code;

   assign op       = op_type'(item.op);
   assign req_kind = kind_type'(item.transfer_kind);
   assign code     = status_type'(item.status_code);
   assign send_clamp = (item.send_count > SEND_MAX) ? SEND_MAX : item.send_count;
   assign pos_inc  = recv_pos_ff + 8'd1;

   always_comb begin
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      send_len_in  = send_len_ff;
      recv_len_in  = recv_len_ff;
      sent_in      = sent_ff;
      recv_pos_in  = recv_pos_ff;
      slave_pos_in = slave_pos_ff;
      busy_in      = busy_ff;
      ok_in        = ok_ff;
      own_addr_in  = csr_we ? csr_wdata : own_addr_ff;
      idle_ret     = 1'b0;

      result = '0;
      result.ack_next = 1'b1;

      case (op)
         OP_START: begin
            if (!busy_ff && (req_kind != KIND_NONE)) begin
               result.accepted    = 1'b1;
               result.issue_start = 1'b1;
               kind_in     = req_kind;
               addr_in     = item.target_addr;
               send_len_in = (req_kind != KIND_RECV) ? send_clamp : 8'd0;
               recv_len_in = (req_kind != KIND_SEND) ? item.recv_count : 8'd0;
               recv_pos_in = 8'd0;
               busy_in     = 1'b1;
               ok_in       = 1'b0;
            end
         end
         OP_EVENT: begin
            case (code)
               ST_START: begin
                  if (kind_ff == KIND_NONE) begin
                     idle_ret = 1'b1;
                  end else begin
                     busy_in = 1'b1;
                     ok_in   = 1'b0;
                     sent_in = 8'd0;
                     result.drive_byte  = {addr_ff, (kind_ff == KIND_RECV)};
                     result.drive_valid = 1'b1;
                  end
               end
               ST_REP_START: begin
                  if (kind_ff == KIND_NONE) begin
                     idle_ret = 1'b1;
                  end else begin
                     result.drive_byte  = {addr_ff, READ_BIT};
                     result.drive_valid = 1'b1;
                  end
               end
               ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
                  if (sent_ff >= send_len_ff) begin
                     if (kind_ff == KIND_SEND_RECV) begin
                        result.issue_start = 1'b1;
                     end else begin
                        result.issue_stop = 1'b1;
                        ok_in    = 1'b1;
                        idle_ret = 1'b1;
                     end
                  end else begin
                     // sent_ff is below send_len, so below the buffer depth
                     result.drive_byte  = tx_byte;
                     result.drive_valid = 1'b1;
                     sent_in = sent_ff + 8'd1;
                  end
               end
               ST_ARB_LOST: begin
                  result.issue_start = 1'b1;
               end
               ST_MR_SLA_ACK: begin
                  recv_pos_in = 8'd0;
                  result.ack_next = (recv_len_ff > 8'd1);
               end
               ST_MR_DATA_ACK, ST_MR_DATA_NACK: begin
                  result.rx_valid    = 1'b1;
                  result.rx_position = recv_pos_ff[6:0];
                  result.rx_value    = item.bus_byte;
                  recv_pos_in = pos_inc;
                  if (code == ST_MR_DATA_ACK) begin
                     // nack the byte that will be the last one
                     result.ack_next = (({1'b0, pos_inc} + 9'd1) < {1'b0, recv_len_ff});
                  end else begin
                     result.issue_stop = 1'b1;
                     ok_in    = 1'b1;
                     idle_ret = 1'b1;
                  end
               end
               ST_SR_SLA_ACK: begin
                  busy_in      = 1'b1;
                  slave_pos_in = 8'd0;
               end
               ST_SR_ARB_LOST: begin
                  result.ack_next = 1'b0;
               end
               ST_SR_DATA_ACK: begin
                  if (slave_pos_ff != 8'hff) begin
                     slave_pos_in = slave_pos_ff + 8'd1;
                  end
               end
               ST_SR_STOP: begin
                  result.slave_packet_len = slave_pos_ff;
                  ok_in    = 1'b1;
                  idle_ret = 1'b1;
               end
               ST_ST_SLA_ACK, ST_ST_DATA_ACK, ST_ST_DATA_NACK, ST_ST_LAST_ACK,
               ST_NO_INFO: begin
               end
               ST_BUS_ERROR: begin
                  result.issue_stop = 1'b1;
                  idle_ret = 1'b1;
               end
               default: begin
                  idle_ret = 1'b1;
               end
            endcase
         end
         default: begin
         end
      endcase

      if (idle_ret) begin
         own_addr_in  = OWN_ADDR_DEFAULT;
         kind_in      = KIND_NONE;
         addr_in      = 7'd0;
         send_len_in  = 8'd0;
         recv_len_in  = 8'd0;
         sent_in      = 8'd0;
         slave_pos_in = 8'd0;
         busy_in      = 1'b0;
      end

      result.busy_flag = busy_in;
      result.result_ok = ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= KIND_NONE;
         addr_ff      <= 7'd0;
         send_len_ff  <= 8'd0;
         recv_len_ff  <= 8'd0;
         sent_ff      <= 8'd0;
         recv_pos_ff  <= 8'd0;
         slave_pos_ff <= 8'd0;
         busy_ff      <= 1'b0;
         ok_ff        <= 1'b0;
         own_addr_ff  <= OWN_ADDR_DEFAULT;
      end else if (flow.step) begin
         kind_ff      <= kind_in;
         addr_ff      <= addr_in;
         send_len_ff  <= send_len_in;
         recv_len_ff  <= recv_len_in;
         sent_ff      <= sent_in;
         recv_pos_ff  <= recv_pos_in;
         slave_pos_ff <= slave_pos_in;
         busy_ff      <= busy_in;
         ok_ff        <= ok_in;
         own_addr_ff  <= own_addr_in;
      end else if (csr_we) begin
         own_addr_ff  <= csr_wdata;
      end
   end

   // the buffer always holds the byte at the current send position ready
   assign mem_we    = flow.step & (op == OP_LOAD);
   assign mem_raddr = flow.step ? sent_in[BUF_AW-1:0] : sent_ff[BUF_AW-1:0];

   i2cts_tx_mem u_tx_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (item.load_index[BUF_AW-1:0]),
      .wr_data (item.load_byte),
      .rd_addr (mem_raddr),
      .rd_data (tx_byte)
   );

endmodule

// ===== rtl/i2c_transfer_sequencer_unit.sv =====
// i2c_transfer_sequencer_unit: top level of the two-wire transfer sequencer.
// Depends on i2cts_pkg, i2cts_in_stage and i2cts_seq_core.
`timescale 1ns / 1ps

// Takes requests (transmit byte load, transfer start, bus status event or no-op)
// and returns exactly one response per request, in order. A request is registered
// in the input register on acceptance and stays there while the response register
// is stalled; its decode is then captured in the response register. Sustained rate
// is one request per cycle while rsp_stall is low; it is set by the single state
// update in the sequencing core, which also keeps the next transmit byte prefetched
// from the 128-byte buffer so a send never waits on the memory read. The buffer
// needs no clearing after reset if the user sends only loaded positions; the block
// does not enforce this. The user writes the own-address register through the csr
// port only while no request is in flight, unenforced by the block; it resets to 2.

module i2c_transfer_sequencer_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  i2cts_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output i2cts_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_data
);
   import i2cts_pkg::*;

   flow_type flow;
   req_type  item;
   rsp_type  result;
   rsp_type  rsp_data_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     out_free;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign csr_ready = 1'b1;

   i2cts_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_free  (out_free),
      .flow      (flow),
      .item      (item)
   );

   i2cts_seq_core u_seq_core (
      .clock     (clock),
      .reset     (reset),
      .flow      (flow),
      .item      (item),
      .csr_we    (csr_valid & csr_ready),
      .csr_wdata (csr_data),
      .result    (result)
   );

   assign rsp_valid_in = flow.step | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (flow.step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for i2c_transfer_sequencer_unit. It drives directed and
// random requests, predicts every response in-line and checks them in order.
// Depends on i2cts_pkg and the sequencer rtl only.

module tb_top;
   import i2cts_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 255;
   localparam logic [4:0] ST_UNKNOWN = 5'd31;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_data = '0;

   i2c_transfer_sequencer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // sequencer state as the testbench sees it
   logic [7:0] tx_mem [BUF_DEPTH];
   bit         tx_loaded [BUF_DEPTH];
   logic [7:0] slave_mem [BUF_DEPTH];
   logic [6:0] own_addr;
   kind_type   cur_kind;
   logic [6:0] cur_addr;
   logic [7:0] send_len, recv_len, sent_cnt, recv_idx, slave_idx;
   logic       busy, done_ok;

   rsp_type        pending_rsp_q[$];
   req_type        plan_q[$];
   stim_row_type   stim_table[$];
   int             fail_cnt = 0;
   int             quiet_cycles = 0;
   int             burst_left = 0;
   bit             sender_steady = 1'b0;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void return_to_idle();
      own_addr = OWN_ADDR_DEFAULT;
      cur_kind = KIND_NONE;
      cur_addr = '0;
      send_len = '0;
      recv_len = '0;
      sent_cnt = '0;
      slave_idx = '0;
      busy = 1'b0;
   endfunction

   function automatic rsp_type advance_sequencer(req_type r);
      rsp_type o;
      logic [7:0] scnt;
      o = '0;
      o.ack_next = 1'b1;
      case (r.op)
         OP_LOAD: begin
            tx_mem[r.load_index] = r.load_byte;
            tx_loaded[r.load_index] = 1'b1;
         end
         OP_START: begin
            if (!busy && r.transfer_kind != KIND_NONE) begin
               scnt = (r.send_count > SEND_MAX) ? SEND_MAX : r.send_count;
               o.accepted = 1'b1;
               o.issue_start = 1'b1;
               cur_kind = kind_type'(r.transfer_kind);
               cur_addr = r.target_addr;
               send_len = (cur_kind != KIND_RECV) ? scnt : 8'd0;
               recv_len = (cur_kind != KIND_SEND) ? r.recv_count : 8'd0;
               recv_idx = '0;
               busy = 1'b1;
               done_ok = 1'b0;
            end
         end
         OP_EVENT: begin
            case (r.status_code)
               ST_START: begin
                  if (cur_kind == KIND_NONE) begin
                     return_to_idle();
                  end else begin
                     busy = 1'b1;
                     done_ok = 1'b0;
                     sent_cnt = '0;
                     o.drive_byte = {cur_addr, (cur_kind == KIND_RECV) ? READ_BIT : 1'b0};
                     o.drive_valid = 1'b1;
                  end
               end
               ST_REP_START: begin
                  if (cur_kind == KIND_NONE) begin
                     return_to_idle();
                  end else begin
                     o.drive_byte = {cur_addr, READ_BIT};
                     o.drive_valid = 1'b1;
                  end
               end
               ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
                  if (sent_cnt >= send_len) begin
                     if (cur_kind == KIND_SEND_RECV) begin
                        o.issue_start = 1'b1;
                     end else begin
                        o.issue_stop = 1'b1;
                        done_ok = 1'b1;
                        return_to_idle();
                     end
                  end else begin
                     o.drive_byte = tx_mem[sent_cnt[6:0]];
                     o.drive_valid = 1'b1;
                     sent_cnt = sent_cnt + 8'd1;
                  end
               end
               ST_ARB_LOST: o.issue_start = 1'b1;
               ST_MR_SLA_ACK: begin
                  recv_idx = '0;
                  o.ack_next = (recv_len > 8'd1);
               end
               ST_MR_DATA_ACK, ST_MR_DATA_NACK: begin
                  o.rx_valid = 1'b1;
                  o.rx_position = recv_idx[6:0];
                  o.rx_value = r.bus_byte;
                  recv_idx = recv_idx + 8'd1;
                  if (r.status_code == ST_MR_DATA_ACK) begin
                     // nack the byte that will be the last one
                     o.ack_next = ({1'b0, recv_idx} + 9'd1 < {1'b0, recv_len});
                  end else begin
                     o.issue_stop = 1'b1;
                     done_ok = 1'b1;
                     return_to_idle();
                  end
               end
               ST_SR_SLA_ACK: begin
                  busy = 1'b1;
                  slave_idx = '0;
               end
               ST_SR_ARB_LOST: o.ack_next = 1'b0;
               ST_SR_DATA_ACK: begin
                  if (slave_idx < 8'(BUF_DEPTH)) slave_mem[slave_idx[6:0]] = r.bus_byte;
                  if (slave_idx != 8'hFF) slave_idx = slave_idx + 8'd1;
               end
               ST_SR_STOP: begin
                  o.slave_packet_len = slave_idx;
                  done_ok = 1'b1;
                  return_to_idle();
               end
               ST_ST_SLA_ACK, ST_ST_DATA_ACK, ST_ST_DATA_NACK, ST_ST_LAST_ACK, ST_NO_INFO: ;
               ST_BUS_ERROR: begin
                  o.issue_stop = 1'b1;
                  return_to_idle();
               end
               default: return_to_idle();
            endcase
         end
         default: ;
      endcase
      o.busy_flag = busy;
      o.result_ok = done_ok;
      return o;
   endfunction

   // a send acknowledge must never reach a transmit entry that was not loaded
   function automatic bit unloaded_send(req_type r);
      return r.op == OP_EVENT &&
             (r.status_code == ST_MT_SLA_ACK || r.status_code == ST_MT_DATA_ACK) &&
             sent_cnt < send_len && !tx_loaded[sent_cnt[6:0]];
   endfunction

   function automatic rsp_type quiet_rsp(logic busy_v, logic ok_v);
      rsp_type o;
      o = '0;
      o.ack_next = 1'b1;
      o.busy_flag = busy_v;
      o.result_ok = ok_v;
      return o;
   endfunction

   function automatic req_type load_req(logic [6:0] idx, logic [7:0] b);
      req_type r;
      r = '0;
      r.op = OP_LOAD;
      r.load_index = idx;
      r.load_byte = b;
      return r;
   endfunction

   function automatic req_type start_req(kind_type k, logic [6:0] a, logic [7:0] s,
                                         logic [7:0] n);
      req_type r;
      r = '0;
      r.op = OP_START;
      r.transfer_kind = k;
      r.target_addr = a;
      r.send_count = s;
      r.recv_count = n;
      return r;
   endfunction

   function automatic req_type event_req(logic [4:0] code, logic [7:0] b);
      req_type r;
      r = '0;
      r.op = OP_EVENT;
      r.status_code = code;
      r.bus_byte = b;
      return r;
   endfunction

   function automatic void add_row(req_type r, bit typed, rsp_type want);
      stim_row_type row;
      row.r = r;
      row.typed = typed;
      row.want = want;
      stim_table.push_back(row);
   endfunction

   function automatic req_type any_request();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic req_type bus_event(logic [4:0] code);
      req_type r;
      r = any_request();
      r.op = OP_EVENT;
      r.status_code = code;
      return r;
   endfunction

   function automatic logic [7:0] pick_length();
      int dice;
      dice = $urandom_range(0, 99);
      if (dice < 85) return 8'($urandom_range(0, 6));
      if (dice < 97) return 8'($urandom_range(7, 40));
      return 8'($urandom_range(129, 255));
   endfunction

   // queue one step of a sequence, now and then with noise in front or the step lost
   task automatic plan(req_type r);
      int dice;
      dice = $urandom_range(0, 99);
      if (dice < 3) plan_q.push_back(any_request());
      if (dice != 99) plan_q.push_back(r);
   endtask

   task automatic plan_sequence();
      req_type r;
      int      flavor, nbytes, nrecv;
      flavor = $urandom_range(0, 99);
      if (flavor < 25) begin
         repeat ($urandom_range(0, 4)) begin
            r = any_request();
            r.op = OP_LOAD;
            r.load_index = 7'($urandom_range(0, 7));
            plan(r);
         end
         r = any_request();
         r.op = OP_START;
         r.transfer_kind = KIND_SEND;
         r.send_count = pick_length();
         nbytes = (r.send_count > SEND_MAX) ? BUF_DEPTH : int'(r.send_count);
         plan(r);
         plan(bus_event(ST_START));
         plan(bus_event(ST_MT_SLA_ACK));
         repeat (nbytes) plan(bus_event(ST_MT_DATA_ACK));
      end else if (flavor < 45) begin
         r = any_request();
         r.op = OP_START;
         r.transfer_kind = KIND_RECV;
         r.recv_count = pick_length();
         nbytes = int'(r.recv_count);
         if ($urandom_range(0, 24) == 0) nbytes = $urandom_range(256, 280);
         else if (nbytes > 40) nbytes = $urandom_range(120, 160);
         plan(r);
         plan(bus_event(ST_START));
         plan(bus_event(ST_MR_SLA_ACK));
         if (nbytes > 1) repeat (nbytes - 1) plan(bus_event(ST_MR_DATA_ACK));
         plan(bus_event(ST_MR_DATA_NACK));
      end else if (flavor < 65) begin
         nbytes = $urandom_range(0, 5);
         nrecv = $urandom_range(0, 5);
         r = any_request();
         r.op = OP_START;
         r.transfer_kind = KIND_SEND_RECV;
         r.send_count = 8'(nbytes);
         r.recv_count = 8'(nrecv);
         plan(r);
         plan(bus_event(ST_START));
         plan(bus_event(ST_MT_SLA_ACK));
         repeat (nbytes) plan(bus_event(ST_MT_DATA_ACK));
         plan(bus_event(ST_REP_START));
         plan(bus_event(ST_MR_SLA_ACK));
         if (nrecv > 1) repeat (nrecv - 1) plan(bus_event(ST_MR_DATA_ACK));
         plan(bus_event(ST_MR_DATA_NACK));
      end else if (flavor < 80) begin
         if ($urandom_range(0, 4) == 0) plan(bus_event(ST_SR_ARB_LOST));
         plan(bus_event(ST_SR_SLA_ACK));
         flavor = $urandom_range(0, 99);
         if (flavor < 85) nbytes = $urandom_range(0, 8);
         else if (flavor < 97) nbytes = $urandom_range(120, 140);
         else nbytes = $urandom_range(256, 270);
         repeat (nbytes) plan(bus_event(ST_SR_DATA_ACK));
         plan(bus_event(ST_SR_STOP));
      end else if (flavor < 88) begin
         plan(bus_event(ST_ST_SLA_ACK));
         repeat ($urandom_range(0, 3)) plan(bus_event(ST_ST_DATA_ACK));
         plan(bus_event($urandom_range(0, 1) ? ST_ST_LAST_ACK : ST_ST_DATA_NACK));
         plan(bus_event(ST_SR_STOP));
      end else begin
         repeat ($urandom_range(1, 3)) plan_q.push_back(any_request());
         if ($urandom_range(0, 1)) plan_q.push_back(bus_event(5'($urandom_range(16, 31))));
      end
   endtask

   // sender: bursts of requests with random gaps between them
   task automatic push_request(req_type r, bit typed, rsp_type want);
      rsp_type predicted;
      int      gap_len;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap_len = sender_steady ? 0 : $urandom_range(0, 6);
         if (gap_len > 0) begin
            req_valid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      burst_left--;
      predicted = advance_sequencer(r);
      pending_rsp_q.push_back(typed ? want : predicted);
   endtask

   task automatic write_own_address(logic [6:0] v);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      own_addr = v;
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: mismatch on %s: expected %0h, got %0h", $time, name, want, got);
         fail_cnt++;
      end
   endtask

   task automatic compare_rsp(rsp_type want, rsp_type got);
      check_field("accepted", 8'(want.accepted), 8'(got.accepted));
      check_field("drive_byte", want.drive_byte, got.drive_byte);
      check_field("drive_valid", 8'(want.drive_valid), 8'(got.drive_valid));
      check_field("issue_start", 8'(want.issue_start), 8'(got.issue_start));
      check_field("issue_stop", 8'(want.issue_stop), 8'(got.issue_stop));
      check_field("ack_next", 8'(want.ack_next), 8'(got.ack_next));
      check_field("busy_flag", 8'(want.busy_flag), 8'(got.busy_flag));
      check_field("result_ok", 8'(want.result_ok), 8'(got.result_ok));
      check_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
      check_field("rx_position", 8'(want.rx_position), 8'(got.rx_position));
      check_field("rx_value", want.rx_value, got.rx_value);
      check_field("slave_packet_len", want.slave_packet_len, got.slave_packet_len);
   endtask

   // response side: in-order check, stall pattern and watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp_q.size() == 0) begin
               $display("%0t: response with none expected: got %h", $time, rsp_data);
               fail_cnt++;
            end else begin
               compare_rsp(pending_rsp_q.pop_front(), rsp_data);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (mode_left == 0) begin
            mode_left <= $urandom_range(20, 400);
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   initial begin
      req_type r;
      int      n;
      tx_loaded = '{default: 1'b0};
      return_to_idle();
      recv_idx = '0;
      done_ok = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_own_address(7'h7F);

      add_row(event_req(ST_NO_INFO, 8'hFF), 1'b1, quiet_rsp(1'b0, 1'b0));
      // start event with no transfer set up just returns to idle
      add_row(event_req(ST_START, 8'h00), 1'b1, quiet_rsp(1'b0, 1'b0));
      add_row(load_req(7'd0, 8'hFF), 1'b1, quiet_rsp(1'b0, 1'b0));
      add_row(load_req(7'd127, 8'h00), 1'b1, quiet_rsp(1'b0, 1'b0));
      add_row(load_req(7'd1, 8'h5A), 1'b1, quiet_rsp(1'b0, 1'b0));
      add_row(start_req(KIND_NONE, 7'h7F, 8'd1, 8'd1), 1'b1, quiet_rsp(1'b0, 1'b0));
      add_row(start_req(KIND_SEND, 7'h7F, 8'd2, 8'hFF), 1'b0, '0);
      add_row(start_req(KIND_RECV, 7'h00, 8'd0, 8'd1), 1'b1, quiet_rsp(1'b1, 1'b0));
      add_row(event_req(ST_START, 8'h00), 1'b0, '0);
      add_row(event_req(ST_MT_SLA_ACK, 8'h00), 1'b0, '0);
      add_row(event_req(ST_MT_DATA_ACK, 8'h00), 1'b0, '0);
      add_row(event_req(ST_MT_DATA_ACK, 8'h00), 1'b0, '0);
      add_row(start_req(KIND_RECV, 7'h00, 8'hFF, 8'd1), 1'b0, '0);
      add_row(event_req(ST_START, 8'h00), 1'b0, '0);
      add_row(event_req(ST_MR_SLA_ACK, 8'h00), 1'b0, '0);
      add_row(event_req(ST_MR_DATA_NACK, 8'hFF), 1'b0, '0);
      add_row(start_req(KIND_SEND_RECV, 7'h55, 8'd1, 8'd2), 1'b0, '0);
      add_row(event_req(ST_START, 8'h00), 1'b0, '0);
      add_row(event_req(ST_MT_SLA_ACK, 8'h00), 1'b0, '0);
      add_row(event_req(ST_MT_DATA_ACK, 8'h00), 1'b0, '0);
      add_row(event_req(ST_REP_START, 8'h00), 1'b0, '0);
      add_row(event_req(ST_MR_SLA_ACK, 8'h00), 1'b0, '0);
      add_row(event_req(ST_MR_DATA_NACK, 8'hA5), 1'b0, '0);
      add_row(event_req(ST_SR_SLA_ACK, 8'h00), 1'b0, '0);
      add_row(event_req(ST_SR_DATA_ACK, 8'hFF), 1'b0, '0);
      add_row(event_req(ST_SR_STOP, 8'h00), 1'b0, '0);
      add_row(event_req(ST_BUS_ERROR, 8'h00), 1'b0, '0);
      add_row(event_req(ST_UNKNOWN, 8'h00), 1'b1, quiet_rsp(1'b0, 1'b1));
      add_row(start_req(KIND_SEND, 7'h00, 8'd0, 8'd0) | {OP_NOP, 53'd0}, 1'b1,
              quiet_rsp(1'b0, 1'b1));
      foreach (stim_table[i]) push_request(stim_table[i].r, stim_table[i].typed,
                                           stim_table[i].want);

      for (int p = 0; p < PHASES; p++) begin
         write_own_address(p == 0 ? 7'h00 : p == 1 ? 7'h7F : 7'($urandom_range(0, 127)));
         sender_steady = (p == 2);
         n = 0;
         while (n < PHASE_ITEMS) begin
            if (plan_q.size() == 0) plan_sequence();
            r = plan_q.pop_front();
            if (unloaded_send(r)) begin
               plan_q.push_front(r);
               r.op = OP_LOAD;
               r.load_index = sent_cnt[6:0];
            end
            push_request(r, 1'b0, '0);
            n++;
         end
         plan_q.delete();
      end

      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
